// ===== rtl/dee_pkg.sv =====
package dee_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int RAW_ADDR_W = 10;
	localparam int TICKS_W = 16;
	localparam logic [TICKS_W-1:0] TICKS_RST = 16'd16;

	localparam logic [1:0] KIND_READ = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [2:0] SEL_ADDR_HIGH = 3'd0;
	localparam logic [2:0] SEL_ADDR_LOW = 3'd1;
	localparam logic [2:0] SEL_DATA = 3'd2;
	localparam logic [2:0] SEL_CONTROL = 3'd3;
	localparam logic [2:0] SEL_UNLOCK = 3'd4;

	localparam int CTL_MEMSEL = 7;
	localparam int CTL_CFGSEL = 6;
	localparam int CTL_WREN = 2;
	localparam int CTL_WR = 1;
	localparam int CTL_RD = 0;

	localparam logic [7:0] UNLOCK_FIRST = 8'h55;
	localparam logic [7:0] UNLOCK_SECOND = 8'hAA;
	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] reg_sel;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       busy_res;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic clear_en;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic mem_read;
	} sts_t;

endpackage

// ===== rtl/dee_ctrl.sv =====
module dee_ctrl
	import dee_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_stall = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall));
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	assign cmd.accept = accept;
	assign cmd.clear_en = (state_q == ST_CLEAR);
	assign cmd.load = (state_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && sts.mem_read) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/dee_dp.sv =====
module dee_dp
	import dee_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  req_t               req,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [TICKS_W-1:0] cfg_wdata,
	output rsp_t               rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int RED_STEPS = $clog2((1 << RAW_ADDR_W) / DEPTH) + 1;

	typedef logic [AW-1:0] addr_t;
	typedef logic [RAW_ADDR_W:0] raw_t;
	typedef enum logic [1:0] {
		UL_NONE,
		UL_FIRST,
		UL_DONE
	} ul_t;

	logic [7:0]         mem [DEPTH];
	logic [7:0]         rdata_q;
	addr_t              clr_q;
	logic [1:0]         addr_high_q;
	logic [7:0]         addr_low_q;
	logic [7:0]         data_q;
	logic               memsel_q;
	logic               cfgsel_q;
	logic               wren_q;
	ul_t                ul_q;
	ul_t                ul_nx;
	logic [TICKS_W-1:0] busy_q;
	logic [TICKS_W-1:0] busy_nx;
	logic [TICKS_W-1:0] ticks_q;
	rsp_t               rsp_q;
	raw_t               red;
	addr_t              mem_addr;
	logic               is_ctrl_wr;
	logic               data_side;
	logic               start_go;
	logic               read_go;
	logic [7:0]         rd_val;

	always_comb begin
		red = {1'b0, addr_high_q, addr_low_q};
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (red >= raw_t'(DEPTH << k)) begin
				red = red - raw_t'(DEPTH << k);
			end
		end
	end
	assign mem_addr = red[AW-1:0];

	assign is_ctrl_wr = (req.kind == KIND_WRITE) && (req.reg_sel == SEL_CONTROL);
	assign data_side = !req.value[CTL_MEMSEL] && !req.value[CTL_CFGSEL];
	assign start_go = is_ctrl_wr && req.value[CTL_WR] && (busy_q == '0) &&
		(ul_q == UL_DONE) && req.value[CTL_WREN] && data_side;
	assign read_go = is_ctrl_wr && !req.value[CTL_WR] && req.value[CTL_RD] && data_side;

	assign sts.mem_read = read_go;
	assign sts.clear_last = (clr_q == addr_t'(DEPTH - 1));

	always_comb begin
		busy_nx = busy_q;
		if (start_go) begin
			busy_nx = (ticks_q == '0) ? TICKS_W'(1) : ticks_q;
		end else if ((req.kind == KIND_TICK) && (busy_q != '0)) begin
			busy_nx = busy_q - TICKS_W'(1);
		end
	end

	always_comb begin
		ul_nx = ul_q;
		if (req.kind == KIND_WRITE) begin
			if (req.reg_sel == SEL_UNLOCK) begin
				if (req.value == UNLOCK_FIRST) begin
					ul_nx = UL_FIRST;
				end else if ((req.value == UNLOCK_SECOND) && (ul_q == UL_FIRST)) begin
					ul_nx = UL_DONE;
				end else begin
					ul_nx = UL_NONE;
				end
			end else begin
				ul_nx = UL_NONE;
			end
		end
	end

	always_comb begin
		rd_val = '0;
		if (req.kind == KIND_READ) begin
			case (req.reg_sel)
				SEL_ADDR_HIGH: rd_val = {6'b0, addr_high_q};
				SEL_ADDR_LOW:  rd_val = addr_low_q;
				SEL_DATA:      rd_val = data_q;
				SEL_CONTROL:   rd_val = {memsel_q, cfgsel_q, 3'b0, wren_q, busy_q != '0, 1'b0};
				default:       rd_val = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			mem[clr_q] <= ERASED_BYTE;
		end else if (cmd.accept && start_go) begin
			mem[mem_addr] <= data_q;
		end
		if (cmd.accept && read_go) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rsp_q.read_data <= rd_val;
			rsp_q.busy_res <= (busy_nx != '0);
		end
	end
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			addr_high_q <= '0;
			addr_low_q <= '0;
			data_q <= '0;
			memsel_q <= 1'b0;
			cfgsel_q <= 1'b0;
			wren_q <= 1'b0;
			ul_q <= UL_NONE;
			busy_q <= '0;
			ticks_q <= TICKS_RST;
		end else begin
			if (cfg_we) begin
				ticks_q <= cfg_wdata;
			end
			if (cmd.clear_en) begin
				clr_q <= clr_q + addr_t'(1);
			end
			if (cmd.load) begin
				data_q <= rdata_q;
			end
			if (cmd.accept) begin
				busy_q <= busy_nx;
				ul_q <= ul_nx;
				if (req.kind == KIND_WRITE) begin
					case (req.reg_sel)
						SEL_ADDR_HIGH: addr_high_q <= req.value[1:0];
						SEL_ADDR_LOW:  addr_low_q <= req.value;
						SEL_DATA:      data_q <= req.value;
						SEL_CONTROL: begin
							memsel_q <= req.value[CTL_MEMSEL];
							cfgsel_q <= req.value[CTL_CFGSEL];
							wren_q <= req.value[CTL_WREN];
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

// ===== rtl/data_eeprom_controller_core.sv =====
// Register-mapped data EEPROM of DEPTH bytes behind address-high, address-low, data,
// control and unlock registers, plus a tick request that counts down the busy time of a
// byte write. Each accepted request gives exactly one response (register contents for a
// read, zero otherwise, and the busy flag after the request) in an output register. A
// control write that loads the data register from the array (read bit set, write-start
// bit clear, data EEPROM selected) also passes through a load state, since the byte
// array has a registered read port and the data register is loaded in that state.
// A new request is taken, while the block is idle, once the previous response is taken
// or in the cycle it is taken. After reset the block erases every byte to 0xFF in a
// pass over all DEPTH bytes, one byte a cycle, and holds in_stall high meanwhile;
// write_ticks may be written at any time the block is idle, through cfg_we and cfg_wdata.
module data_eeprom_controller_core
	import dee_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  req_t               in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output rsp_t               out_rsp,
	input  logic               cfg_we,
	input  logic [TICKS_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	dee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dee_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (in_req),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (out_rsp)
	);

endmodule

// ===== rtl/dee_checker.sv =====
module dee_checker
	import dee_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input req_t in_req,
	input logic out_valid,
	input logic out_stall,
	input rsp_t out_rsp
);

	logic accept;
	assign accept = in_valid && !in_stall;

	a_hold_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("request taken while response is stalled");

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted request gave no response");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_rsp)))
		else $error("stalled response changed");

	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_req.kind != KIND_READ)) |=> (out_rsp.read_data == '0))
		else $error("non-read request returned data");

	a_unlock_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_req.kind == KIND_READ) && (in_req.reg_sel == SEL_UNLOCK))
		|=> (out_rsp.read_data == '0))
		else $error("unlock register read returned data");

endmodule

bind data_eeprom_controller_core dee_checker u_dee_checker (.*);

// ===== tb/sv/testbench.sv =====
module testbench;
	import dee_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [2:0] SEL_SPARE_LO = 3'd5;
	localparam logic [2:0] SEL_SPARE_HI = 3'd7;
	localparam logic [7:0] C_MEMSEL = 8'd1 << CTL_MEMSEL;
	localparam logic [7:0] C_CFGSEL = 8'd1 << CTL_CFGSEL;
	localparam logic [7:0] C_WREN = 8'd1 << CTL_WREN;
	localparam logic [7:0] C_WR = 8'd1 << CTL_WR;
	localparam logic [7:0] C_RD = 8'd1 << CTL_RD;
	localparam logic [1:0] UNL_NONE = 2'd0;
	localparam logic [1:0] UNL_FIRST = 2'd1;
	localparam logic [1:0] UNL_OPEN = 2'd2;
	localparam int PHASE_ITEMS = 110;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	req_t               in_req = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	rsp_t               out_rsp;
	logic               cfg_we = 1'b0;
	logic [TICKS_W-1:0] cfg_wdata = '0;

	req_t bus_queue[$];
	rsp_t replies_due[$];
	int   queued = 0;
	int   mismatches = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	bit   hold_req = 1'b0;
	int   hold_left = 0;

	logic [7:0]         eeprom_img [0:DEPTH_DEF-1];
	logic [1:0]         m_addr_hi;
	logic [7:0]         m_addr_lo;
	logic [7:0]         m_data;
	logic               m_memsel;
	logic               m_cfgsel;
	logic               m_wren;
	logic [1:0]         m_unlock;
	logic [TICKS_W-1:0] m_busy;
	logic [TICKS_W-1:0] m_ticks;

	data_eeprom_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_rsp(out_rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t eeprom_access(req_t r);
		rsp_t o;
		int a;
		o = '0;
		a = {m_addr_hi, m_addr_lo} % DEPTH_DEF;
		case (r.kind)
		KIND_READ: begin
			case (r.reg_sel)
			SEL_ADDR_HIGH: o.read_data = {6'd0, m_addr_hi};
			SEL_ADDR_LOW: o.read_data = m_addr_lo;
			SEL_DATA: o.read_data = m_data;
			SEL_CONTROL: begin
				o.read_data[CTL_MEMSEL] = m_memsel;
				o.read_data[CTL_CFGSEL] = m_cfgsel;
				o.read_data[CTL_WREN] = m_wren;
				o.read_data[CTL_WR] = (m_busy != 0);
			end
			default: o.read_data = 8'h00;
			endcase
		end
		KIND_WRITE: begin
			if (r.reg_sel == SEL_UNLOCK) begin
				if (r.value == UNLOCK_FIRST)
					m_unlock = UNL_FIRST;
				else if (r.value == UNLOCK_SECOND && m_unlock == UNL_FIRST)
					m_unlock = UNL_OPEN;
				else
					m_unlock = UNL_NONE;
			end else begin
				case (r.reg_sel)
				SEL_ADDR_HIGH: m_addr_hi = r.value[1:0];
				SEL_ADDR_LOW: m_addr_lo = r.value;
				SEL_DATA: m_data = r.value;
				SEL_CONTROL: begin
					m_memsel = r.value[CTL_MEMSEL];
					m_cfgsel = r.value[CTL_CFGSEL];
					m_wren = r.value[CTL_WREN];
					if (r.value[CTL_WR]) begin
						if (m_busy == 0 && m_unlock == UNL_OPEN && m_wren && !m_memsel &&
								!m_cfgsel) begin
							eeprom_img[a] = m_data;
							m_busy = (m_ticks == 0) ? 16'd1 : m_ticks;
						end
					end else if (r.value[CTL_RD] && !m_memsel && !m_cfgsel) begin
						m_data = eeprom_img[a];
					end
				end
				default: ;
				endcase
				m_unlock = UNL_NONE;
			end
		end
		KIND_TICK: begin
			if (m_busy != 0)
				m_busy = m_busy - 1'b1;
		end
		default: ;
		endcase
		o.busy_res = (m_busy != 0);
		return o;
	endfunction

	function automatic logic [9:0] pick_addr();
		if ($urandom_range(3) == 0)
			return 10'($urandom_range(1023));
		return 10'(($urandom_range(15) * 67) % 1024);
	endfunction

	task automatic put(logic [1:0] k, logic [2:0] s, logic [7:0] v);
		req_t r;
		r.kind = k;
		r.reg_sel = s;
		r.value = v;
		bus_queue.push_back(r);
		queued++;
	endtask

	task automatic queue_store(logic [9:0] a, logic [7:0] d, bit broken);
		logic [7:0] ctl;
		int flaw;
		ctl = 8'($urandom());
		ctl[CTL_MEMSEL] = 1'b0;
		ctl[CTL_CFGSEL] = 1'b0;
		ctl[CTL_WREN] = 1'b1;
		ctl[CTL_WR] = 1'b1;
		flaw = broken ? $urandom_range(1, 4) : 0;
		put(KIND_WRITE, SEL_ADDR_HIGH, {6'($urandom()), a[9:8]});
		put(KIND_WRITE, SEL_ADDR_LOW, a[7:0]);
		put(KIND_WRITE, SEL_DATA, d);
		put(KIND_WRITE, SEL_UNLOCK, (flaw == 1) ? 8'($urandom()) : UNLOCK_FIRST);
		if (flaw == 2)
			put(KIND_WRITE, 3'($urandom_range(3)), 8'($urandom()));
		else if ($urandom_range(3) == 0)
			put($urandom_range(1) ? KIND_READ : KIND_TICK, 3'($urandom()), 8'($urandom()));
		put(KIND_WRITE, SEL_UNLOCK, UNLOCK_SECOND);
		if (flaw == 3)
			ctl[CTL_WREN] = 1'b0;
		if (flaw == 4)
			ctl = ctl | ($urandom_range(1) ? C_MEMSEL : C_CFGSEL);
		put(KIND_WRITE, SEL_CONTROL, ctl);
		if ($urandom_range(1))
			put(KIND_READ, SEL_CONTROL, 8'($urandom()));
	endtask

	task automatic queue_fetch(logic [9:0] a);
		logic [7:0] ctl;
		ctl = 8'($urandom());
		ctl[CTL_MEMSEL] = ($urandom_range(5) == 0);
		ctl[CTL_CFGSEL] = ($urandom_range(5) == 0);
		ctl[CTL_WR] = 1'b0;
		ctl[CTL_RD] = 1'b1;
		put(KIND_WRITE, SEL_ADDR_HIGH, {6'($urandom()), a[9:8]});
		put(KIND_WRITE, SEL_ADDR_LOW, a[7:0]);
		put(KIND_WRITE, SEL_CONTROL, ctl);
		put(KIND_READ, SEL_DATA, 8'($urandom()));
		if ($urandom_range(1))
			put(KIND_READ, SEL_CONTROL, 8'($urandom()));
	endtask

	task automatic fill_random(int n);
		int start;
		start = queued;
		while (queued - start < n) begin
			case ($urandom_range(9))
			0, 1, 2: queue_store(pick_addr(), 8'($urandom()), 1'b0);
			3: queue_store(pick_addr(), 8'($urandom()), 1'b1);
			4, 5: queue_fetch(pick_addr());
			6, 7: begin
				repeat ($urandom_range(1, 12))
					put(KIND_TICK, 3'($urandom()), 8'($urandom()));
			end
			8: put(KIND_READ, 3'($urandom()), 8'($urandom()));
			default: put(2'($urandom()), 3'($urandom()), 8'($urandom()));
			endcase
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (bus_queue.size() != 0 || in_valid || replies_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_write_ticks(logic [TICKS_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_ticks = v;
	endtask

	task automatic run_phase(logic [TICKS_W-1:0] ticks, int spct, int rpct, bit hold);
		set_write_ticks(ticks);
		@(negedge clk);
		send_idle_pct = spct;
		recv_stall_pct = rpct;
		fill_random(PHASE_ITEMS);
		if (hold)
			hold_req = 1'b1;
		drain();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				replies_due.push_back(eeprom_access(in_req));
			if (bus_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_req <= bus_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_req <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected response: data %02h busy %0d",
						out_rsp.read_data, out_rsp.busy_res);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (out_rsp.read_data !== want.read_data ||
						out_rsp.busy_res !== want.busy_res) begin
					if (mismatches < 10)
						$display("mismatch: expected data %02h busy %0d, got data %02h busy %0d",
							want.read_data, want.busy_res, out_rsp.read_data,
							out_rsp.busy_res);
					mismatches++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < DEPTH_DEF; i++)
			eeprom_img[i] = ERASED_BYTE;
		m_addr_hi = '0;
		m_addr_lo = '0;
		m_data = '0;
		m_memsel = 1'b0;
		m_cfgsel = 1'b0;
		m_wren = 1'b0;
		m_unlock = UNL_NONE;
		m_busy = '0;
		m_ticks = TICKS_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		put(KIND_READ, SEL_ADDR_HIGH, 8'hFF);
		put(KIND_READ, SEL_ADDR_LOW, 8'hFF);
		put(KIND_READ, SEL_DATA, 8'hFF);
		put(KIND_READ, SEL_CONTROL, 8'hFF);
		put(KIND_READ, SEL_UNLOCK, 8'hFF);
		put(KIND_WRITE, SEL_ADDR_HIGH, 8'hFF);
		put(KIND_WRITE, SEL_ADDR_LOW, 8'hFF);
		put(KIND_WRITE, SEL_DATA, 8'h00);
		put(KIND_WRITE, SEL_UNLOCK, UNLOCK_SECOND);
		put(KIND_WRITE, SEL_UNLOCK, UNLOCK_FIRST);
		put(KIND_WRITE, SEL_UNLOCK, UNLOCK_SECOND);
		put(KIND_WRITE, SEL_CONTROL, C_WREN | C_WR | C_RD);
		put(KIND_READ, SEL_CONTROL, 8'h00);
		put(KIND_WRITE, SEL_UNLOCK, UNLOCK_FIRST);
		put(KIND_WRITE, SEL_UNLOCK, UNLOCK_SECOND);
		put(KIND_WRITE, SEL_CONTROL, C_WREN | C_WR);
		put(KIND_WRITE, SEL_CONTROL, C_MEMSEL | C_CFGSEL | C_RD);
		put(KIND_WRITE, SEL_CONTROL, C_RD);
		put(KIND_READ, SEL_DATA, 8'h00);
		put(KIND_WRITE, SEL_SPARE_HI, UNLOCK_SECOND);
		put(KIND_READ, SEL_SPARE_LO, 8'h00);
		put(KIND_SPARE, SEL_SPARE_HI, UNLOCK_FIRST);
		put(KIND_TICK, SEL_ADDR_HIGH, 8'h00);
		put(KIND_READ, SEL_CONTROL, 8'h00);
		drain();

		run_phase(16'd1, 0, 0, 1'b1);
		run_phase(16'd0, 86, 0, 1'b0);
		run_phase(16'($urandom_range(2, 40)), 0, 86, 1'b0);
		run_phase(16'($urandom_range(1, 20)), 26, 26, 1'b0);
		run_phase(16'hFFFF, 0, 0, 1'b0);

		if (mismatches == 0 && replies_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
